FILE: hdl/fsv_pkg.sv
// Package with the shared types and character codes of the FASTA stream validator.
`timescale 1ns / 1ps

package fsv_pkg;

  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNul   = 8'h00;

  typedef enum logic [2:0] {
    ST_VALID     = 3'd0,
    ST_NULL      = 3'd1,
    ST_EMPTY_SEQ = 3'd2,
    ST_EMPTY_HDR = 3'd3,
    ST_DATA_PRE  = 3'd4,
    ST_NO_SEQS   = 3'd5,
    ST_LAST_HDR  = 3'd6
  } status_t;

  typedef enum logic [4:0] {
    MODE_PRE    = 5'b00001,
    MODE_HSTART = 5'b00010,
    MODE_HBODY  = 5'b00100,
    MODE_SEQ    = 5'b01000,
    MODE_DRAIN  = 5'b10000
  } mode_t;

  typedef struct packed {
    logic    valid;
    status_t status;
  } res_t;

  function automatic logic is_eol(input logic [7:0] c);
    return (c == ChLf) || (c == ChCr);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

endpackage

FILE: hdl/fsv_parse.sv
// Parser state and per-byte verdict logic of the FASTA stream validator.
`timescale 1ns / 1ps

module fsv_parse (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            beat_en,
  input  logic [7:0]      byte_value,
  input  logic            last_byte,
  input  logic            allow_empty_hdr,
  output fsv_pkg::res_t   res
);
  import fsv_pkg::*;

  mode_t   mode_r, mode_nxt;
  logic    seen_r, seen_nxt;
  logic    err;
  status_t err_code;
  logic    draining;

  always_comb begin
    mode_nxt = mode_r;
    seen_nxt = seen_r;
    err      = 1'b0;
    err_code = ST_NULL;
    draining = 1'b0;
    res      = '{valid: 1'b0, status: ST_VALID};

    unique case (mode_r)
      MODE_PRE: begin
        if (is_blank(byte_value) || is_eol(byte_value)) begin
          mode_nxt = MODE_PRE;
        end else if (byte_value == ChNul) begin
          err      = 1'b1;
          err_code = ST_NULL;
        end else if (byte_value == ChGt) begin
          seen_nxt = 1'b0;
          mode_nxt = MODE_HSTART;
        end else begin
          err      = 1'b1;
          err_code = ST_DATA_PRE;
        end
      end
      MODE_HSTART: begin
        if (is_eol(byte_value)) begin
          if (allow_empty_hdr) begin
            mode_nxt = MODE_SEQ;
          end else begin
            err      = 1'b1;
            err_code = ST_EMPTY_HDR;
          end
        end else begin
          mode_nxt = MODE_HBODY;
        end
      end
      MODE_HBODY: begin
        if (is_eol(byte_value)) begin
          mode_nxt = MODE_SEQ;
        end
      end
      MODE_SEQ: begin
        if (byte_value == ChNul) begin
          err      = 1'b1;
          err_code = ST_NULL;
        end else if (byte_value == ChGt) begin
          if (!seen_r) begin
            err      = 1'b1;
            err_code = ST_EMPTY_SEQ;
          end else begin
            seen_nxt = 1'b0;
            mode_nxt = MODE_HSTART;
          end
        end else if (!(is_blank(byte_value) || is_eol(byte_value))) begin
          seen_nxt = 1'b1;
        end
      end
      default: begin
        draining = 1'b1;
      end
    endcase

    if (draining) begin
      // Bytes after an error are dropped; the last one rearms the parser.
      if (last_byte) begin
        mode_nxt = MODE_PRE;
        seen_nxt = 1'b0;
      end
    end else if (err) begin
      res = '{valid: 1'b1, status: err_code};
      if (last_byte) begin
        mode_nxt = MODE_PRE;
        seen_nxt = 1'b0;
      end else begin
        mode_nxt = MODE_DRAIN;
      end
    end else if (last_byte) begin
      if (mode_nxt == MODE_PRE) begin
        res = '{valid: 1'b1, status: ST_NO_SEQS};
      end else if (!seen_nxt) begin
        res = '{valid: 1'b1, status: ST_LAST_HDR};
      end else begin
        res = '{valid: 1'b1, status: ST_VALID};
      end
      mode_nxt = MODE_PRE;
      seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PRE;
      seen_r <= 1'b0;
    end else if (beat_en) begin
      mode_r <= mode_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

FILE: hdl/fsv_out_buf.sv
// Two-entry result buffer that decouples the parser from the result channel.
`timescale 1ns / 1ps

module fsv_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fsv_pkg::status_t  push_status,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output fsv_pkg::status_t  out_status
);
  import fsv_pkg::*;

  status_t    mem_r [2];
  logic       rd_ptr_r, rd_ptr_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid  = (cnt_r != 2'd0);
  assign out_status = mem_r[rd_ptr_r];
  assign pop        = out_valid && !out_stall;
  // A slot is free now or is freed by the beat leaving this cycle.
  assign room       = (cnt_r != 2'd2) || pop;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r ^ pop;
    wr_ptr_nxt = wr_ptr_r ^ push;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_status;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("result buffer count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && (cnt_r == 2'd2) && !pop))
    else $error("result buffer written while full");
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 2'd1))
    else $error("result buffer count did not drop on pop");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (rd_ptr_r == wr_ptr_r))
    else $error("result buffer pointers disagree with count");
`endif

endmodule

FILE: hdl/fasta_stream_validator_core.sv
// Top level of the FASTA stream validator: input register, parser and result buffer.
// A result passes from the input register through the parser into the result buffer, which drives out_valid.
// Throughput: one byte per cycle while the result buffer has room; the parser updates its state once per byte.
// The two-entry result buffer keeps input flowing while one result waits.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to
// awaiting the first header with empty headers rejected.
`timescale 1ns / 1ps

module fasta_stream_validator_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte_value,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output fsv_pkg::status_t  out_status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_allow_empty_hdr
);
  import fsv_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       skip_r;
  logic       in_accept;
  logic       s1_adv;
  logic       room;
  res_t       res;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid_r && room;
  assign in_stall  = s1_valid_r && !room;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      skip_r     <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        skip_r <= cfg_allow_empty_hdr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_byte_value;
      s1_last_r <= in_last_byte;
    end
  end

  fsv_parse u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .beat_en         (s1_adv),
    .byte_value      (s1_byte_r),
    .last_byte       (s1_last_r),
    .allow_empty_hdr (skip_r),
    .res             (res)
  );

  fsv_out_buf u_out_buf (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (s1_adv && res.valid),
    .push_status (res.status),
    .room        (room),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status)
  );

`ifndef SYNTHESIS
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid && out_stall))
    else $error("input stalled without a blocked result");
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_byte_r) && $stable(s1_last_r)))
    else $error("held input beat changed");
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty input register");
`endif

endmodule
